[rtl/spi_mra_pkg.sv]
// shared types and constants for the spi master register access block
package spi_mra_pkg;

    localparam int unsigned MAX_PAYLOAD_DEF = 31;
    localparam int unsigned BITS_PER_BYTE   = 8;
    localparam int unsigned BIT_W           = $clog2(BITS_PER_BYTE);

    localparam logic [7:0] CMD_READ_BIT = 8'h80;
    localparam logic [7:0] ADDR_MASK    = 8'h7F;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPI_MODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE   = 1'b1;

    localparam logic [1:0] SUB_SETUP  = 2'd0;
    localparam logic [1:0] SUB_ACTIVE = 2'd1;
    localparam logic [1:0] SUB_HOLD   = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FALL,
        ST_BITS,
        ST_RISE
    } t_ser_state;

    typedef struct packed {
        logic       emit;
        logic       cs_fall;
        logic       finish;
        logic       idle;
        logic       cpha;
        logic [7:0] tx;
        logic [7:0] rx;
    } t_job;

    typedef struct packed {
        logic       sck;
        logic       mosi;
        logic       cs_n;
        logic       sample;
        logic [7:0] rx_byte;
        logic       rx_valid;
        logic       end_of_run;
    } t_pin;

endpackage

[rtl/spi_mra_ctrl.sv]
// transaction control: configuration, command building and payload limit
module spi_mra_ctrl
    import spi_mra_pkg::*;
#(
    parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_accept,
    input  logic                  i_first,
    input  logic                  i_operation,
    input  logic [7:0]            i_reg_addr,
    input  logic [7:0]            i_write_data,
    input  logic                  i_last,
    input  logic [7:0]            i_miso_bits,
    output t_job                  o_job
);

    localparam int unsigned CNT_W = $clog2(MAX_PAYLOAD + 1);

    logic [1:0]       r_spi_mode;
    logic             r_enable;
    logic             r_in_trans;
    logic             r_is_write;
    logic [CNT_W-1:0] r_count;
    logic             r_dropping;

    logic             n_in_trans;
    logic             n_is_write;
    logic [CNT_W-1:0] n_count;
    logic             n_dropping;
    logic [CNT_W-1:0] w_count_inc;
    t_job             w_job;

    assign w_count_inc = r_count + 1'b1;

    always_comb begin
        n_in_trans   = r_in_trans;
        n_is_write   = r_is_write;
        n_count      = r_count;
        n_dropping   = r_dropping;
        w_job.emit    = 1'b0;
        w_job.cs_fall = 1'b0;
        w_job.finish  = i_last;
        w_job.idle    = r_spi_mode[1];
        w_job.cpha    = r_spi_mode[0];
        w_job.tx      = 8'h00;
        w_job.rx      = i_miso_bits;
        if (r_enable) begin
            if (i_first) begin
                n_dropping    = 1'b0;
                n_is_write    = (i_operation == OP_WRITE);
                n_count       = '0;
                w_job.tx      = (i_operation == OP_WRITE) ? (i_reg_addr & ADDR_MASK)
                                                          : (i_reg_addr | CMD_READ_BIT);
                w_job.cs_fall = !r_in_trans;
                w_job.emit    = 1'b1;
                n_in_trans    = !i_last;
            end else if (!r_in_trans) begin
                if (r_dropping && i_last) begin
                    n_dropping = 1'b0;
                end
            end else begin
                w_job.tx   = r_is_write ? i_write_data : 8'h00;
                w_job.emit = 1'b1;
                n_count    = w_count_inc;
                if (!i_last && (w_count_inc >= CNT_W'(MAX_PAYLOAD))) begin
                    w_job.finish = 1'b1;
                    n_dropping   = 1'b1;
                end
                if (w_job.finish) begin
                    n_in_trans = 1'b0;
                end
            end
        end
    end

    assign o_job = w_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spi_mode <= 2'd0;
            r_enable   <= 1'b0;
            r_in_trans <= 1'b0;
            r_is_write <= 1'b0;
            r_count    <= '0;
            r_dropping <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_SPI_MODE: r_spi_mode <= i_cfg_wdata[1:0];
                    CFG_ENABLE:   r_enable   <= i_cfg_wdata[0];
                    default:      ;
                endcase
            end
            if (i_accept) begin
                r_in_trans <= n_in_trans;
                r_is_write <= n_is_write;
                r_count    <= n_count;
                r_dropping <= n_dropping;
            end
        end
    end

endmodule

[rtl/spi_mra_ser.sv]
// pin state serializer with registered result stage
module spi_mra_ser
    import spi_mra_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_accept,
    input  t_job i_job,
    output logic o_in_ready,
    input  logic i_out_ready,
    output logic o_out_valid,
    output t_pin o_out
);

    localparam logic [BIT_W-1:0] LAST_BIT = BIT_W'(BITS_PER_BYTE - 1);

    t_ser_state       r_state, n_state;
    logic [BIT_W-1:0] r_bit, n_bit;
    logic [1:0]       r_sub, n_sub;
    t_job             r_job;
    logic             r_out_valid;
    t_pin             r_out;

    logic w_busy;
    logic w_produce;
    logic w_is_last;
    logic w_tx_bit;
    t_pin w_pin;

    assign w_busy     = (r_state != ST_IDLE);
    assign w_produce  = w_busy && (!r_out_valid || i_out_ready);
    assign w_is_last  = (r_state == ST_RISE) ||
                        ((r_state == ST_BITS) && (r_sub == SUB_HOLD) &&
                         (r_bit == LAST_BIT) && !r_job.finish);
    assign o_in_ready = !w_busy || (w_produce && w_is_last);
    assign w_tx_bit   = r_job.tx[LAST_BIT - r_bit];

    // next state
    always_comb begin
        n_state = r_state;
        n_bit   = r_bit;
        n_sub   = r_sub;
        if (w_produce) begin
            case (r_state)
                ST_FALL: begin
                    n_state = ST_BITS;
                    n_bit   = '0;
                    n_sub   = SUB_SETUP;
                end
                ST_BITS: begin
                    if (r_sub == SUB_HOLD) begin
                        n_sub = SUB_SETUP;
                        if (r_bit == LAST_BIT) begin
                            n_state = r_job.finish ? ST_RISE : ST_IDLE;
                        end else begin
                            n_bit = r_bit + 1'b1;
                        end
                    end else begin
                        n_sub = r_sub + 1'b1;
                    end
                end
                ST_RISE: n_state = ST_IDLE;
                default: n_state = ST_IDLE;
            endcase
        end
        if (i_accept && i_job.emit) begin
            n_state = i_job.cs_fall ? ST_FALL : ST_BITS;
            n_bit   = '0;
            n_sub   = SUB_SETUP;
        end
    end

    // pin levels of the current state
    always_comb begin
        w_pin.sck        = r_job.idle;
        w_pin.mosi       = 1'b0;
        w_pin.cs_n       = 1'b0;
        w_pin.sample     = 1'b0;
        w_pin.rx_byte    = 8'h00;
        w_pin.rx_valid   = 1'b0;
        w_pin.end_of_run = w_is_last;
        case (r_state)
            ST_BITS: begin
                w_pin.mosi = w_tx_bit;
                case (r_sub)
                    SUB_ACTIVE: begin
                        w_pin.sck    = !r_job.idle;
                        w_pin.sample = !r_job.cpha;
                    end
                    SUB_HOLD: begin
                        w_pin.sample = r_job.cpha;
                        if (r_bit == LAST_BIT) begin
                            w_pin.rx_valid = 1'b1;
                            w_pin.rx_byte  = r_job.rx;
                        end
                    end
                    default: ;
                endcase
            end
            ST_RISE: begin
                w_pin.mosi = r_job.tx[0];
                w_pin.cs_n = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_bit       <= '0;
            r_sub       <= SUB_SETUP;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_bit   <= n_bit;
            r_sub   <= n_sub;
            if (w_produce) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && i_job.emit) begin
            r_job <= i_job;
        end
        if (w_produce) begin
            r_out <= w_pin;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`ifndef SYNTHESIS
    a_ready_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_busy && o_in_ready) |-> (w_produce && w_is_last))
        else $error("ready raised while a byte is still being sent");
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready && !i_accept) |=>
        ($stable(r_state) && $stable(r_bit) && $stable(r_sub)))
        else $error("serializer advanced while the result was stalled");
    a_rise_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.cs_n) |-> r_out.end_of_run)
        else $error("cs rise not marked as last result of its request");
    a_rx_cs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.rx_valid) |-> (!r_out.cs_n && (r_out.sck == r_job.idle)))
        else $error("received byte given outside a selected hold state");
`endif

endmodule

[rtl/spi_master_register_access.sv]
// top level of the spi master register access block
//
// Each request on the slave stream is one byte slot of a register access.
// A request with first set sends the command byte (address, bit 7 set for a
// read); later requests send the write data, or zero on a read. The bits
// the slave drives on miso come in with the request. tlast ends the access.
// The master stream gives one pin state per cycle while it is not stalled: cs
// fall (only when cs was inactive), three states per bit MSB first, and cs
// rise when the access ends or the payload limit is hit. tlast marks the last
// state of a request, tuser flags the state that carries the received byte.
// The next request is taken in the cycle the last state of the current one
// moves to the output register, so requests follow with no gap. An accepted
// request is registered in the serializer state and job registers, and its
// first state then moves to the output register. Requests that give no states
// (block disabled, payload outside an access) are taken whenever the serializer idles.
// A stalled receiver holds the output register and the serializer.
// Reset ends any access, so the next one starts with a cs fall, and clears the mode and the enable register.
// Configuration writes: index 0 spi mode (cpol*2+cpha), index 1 enable.
module spi_master_register_access
    import spi_mra_pkg::*;
#(
    parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [23:0]           i_s_axis_tdata,  // reg_addr, write_data, miso_bits
    input  logic [1:0]            i_s_axis_tuser,  // first, operation
    input  logic                  i_s_axis_tlast,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [15:0]           o_m_axis_tdata,  // sck, mosi, cs_n, sample, rx_byte, zero pad
    output logic [0:0]            o_m_axis_tuser,  // rx_valid
    output logic                  o_m_axis_tlast
);

    logic w_accept;
    t_job w_job;
    t_pin w_out;

    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;

    spi_mra_ctrl #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (w_accept),
        .i_first     (i_s_axis_tuser[0]),
        .i_operation (i_s_axis_tuser[1]),
        .i_reg_addr  (i_s_axis_tdata[7:0]),
        .i_write_data(i_s_axis_tdata[15:8]),
        .i_last      (i_s_axis_tlast),
        .i_miso_bits (i_s_axis_tdata[23:16]),
        .o_job       (w_job)
    );

    spi_mra_ser u_ser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_job      (w_job),
        .o_in_ready (o_s_axis_tready),
        .i_out_ready(i_m_axis_tready),
        .o_out_valid(o_m_axis_tvalid),
        .o_out      (w_out)
    );

    assign o_m_axis_tdata = {4'b0000, w_out.rx_byte, w_out.sample, w_out.cs_n,
                             w_out.mosi, w_out.sck};
    assign o_m_axis_tuser = w_out.rx_valid;
    assign o_m_axis_tlast = w_out.end_of_run;

endmodule

[test/tb_top.sv]
// testbench for the spi master register access block: stream driver, pin-state predictor, checker
module tb_top;
    import spi_mra_pkg::*;

    localparam int unsigned PAYLOAD_LIMIT = MAX_PAYLOAD_DEF;
    localparam int unsigned IDLE_LIMIT    = 3000;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned ITEMS_PER_MODE = 54;

    typedef struct {
        logic       first;
        logic       op;
        logic [7:0] addr;
        logic [7:0] wdata;
        logic       last;
        logic [7:0] miso;
    } t_spi_slot;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [23:0]           i_s_axis_tdata = '0;   // reg_addr, write_data, miso_bits
    logic [1:0]            i_s_axis_tuser = '0;   // first, operation
    logic                  i_s_axis_tlast = 1'b0;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [15:0]           o_m_axis_tdata;        // sck, mosi, cs_n, sample, rx_byte, zero pad
    logic [0:0]            o_m_axis_tuser;        // rx_valid
    logic                  o_m_axis_tlast;

    spi_master_register_access dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    // predictor copy of the configuration and the transaction state
    logic [1:0] mode_q = 2'd0;
    logic       en_q = 1'b0;
    logic       tr_active = 1'b0;
    logic       tr_write = 1'b0;
    logic [5:0] pay_cnt = '0;
    logic       drop_mode = 1'b0;
    logic [7:0] rx_sr = '0;
    logic       cs_hi = 1'b1;

    t_spi_slot  slot_q[$];
    t_pin       pending_pins[$];
    t_spi_slot  cur_slot;

    int unsigned n_pushed = 0;
    int unsigned n_taken = 0;
    int unsigned n_states = 0;
    int unsigned n_cutoffs = 0;
    int unsigned n_errors = 0;
    int unsigned burst_left = 0;
    int unsigned gap_left = 0;
    int unsigned cyc = 0;
    int unsigned stall_mode = 0;
    int unsigned idle_cnt = 0;

    function automatic t_pin pin_state(logic sck, logic mosi, logic cs_n, logic smp,
                                       logic [7:0] rxb, logic rxv);
        t_pin p;
        p.sck = sck;
        p.mosi = mosi;
        p.cs_n = cs_n;
        p.sample = smp;
        p.rx_byte = rxb;
        p.rx_valid = rxv;
        p.end_of_run = 1'b0;
        return p;
    endfunction

    function automatic void predict_pins(t_spi_slot s);
        logic       idle;
        logic       cpha;
        logic [7:0] tx;
        logic       bit_out;
        logic       finish;
        if (!en_q) return;
        idle = mode_q[1];
        cpha = mode_q[0];
        bit_out = 1'b0;
        if (s.first) begin
            drop_mode = 1'b0;
            tr_write = (s.op == OP_WRITE);
            pay_cnt = '0;
            tx = tr_write ? (s.addr & ADDR_MASK) : (s.addr | CMD_READ_BIT);
            if (cs_hi) begin
                cs_hi = 1'b0;
                pending_pins.push_back(pin_state(idle, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0));
            end
            tr_active = 1'b1;
            finish = s.last;
        end else begin
            if (!tr_active) begin
                if (drop_mode && s.last) drop_mode = 1'b0;
                return;
            end
            tx = tr_write ? s.wdata : 8'h00;
            pay_cnt = pay_cnt + 6'd1;
            finish = s.last;
            if (!finish && pay_cnt >= PAYLOAD_LIMIT) begin
                finish = 1'b1;
                drop_mode = 1'b1;
                n_cutoffs++;
            end
        end
        for (int i = 7; i >= 0; i--) begin
            bit_out = tx[i];
            rx_sr = {rx_sr[6:0], s.miso[i]};
            pending_pins.push_back(pin_state(idle, bit_out, 1'b0, 1'b0, 8'h00, 1'b0));
            pending_pins.push_back(pin_state(~idle, bit_out, 1'b0, ~cpha, 8'h00, 1'b0));
            pending_pins.push_back(pin_state(idle, bit_out, 1'b0, cpha,
                                             (i == 0) ? rx_sr : 8'h00, i == 0));
        end
        if (finish) begin
            tr_active = 1'b0;
            cs_hi = 1'b1;
            pending_pins.push_back(pin_state(idle, bit_out, 1'b1, 1'b0, 8'h00, 1'b0));
        end
        pending_pins[$].end_of_run = 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        if (n_errors < 20)
            $display("mismatch at %0t: %s got %0h want %0h", $time, what, got, want);
        n_errors++;
    endtask

    // sender: bursts of random length separated by random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                predict_pins(cur_slot);
                n_taken++;
            end
            if (i_s_axis_tvalid && !o_s_axis_tready) begin
                i_s_axis_tvalid <= 1'b1;
            end else if (gap_left != 0) begin
                gap_left--;
                i_s_axis_tvalid <= 1'b0;
            end else if (slot_q.size() != 0) begin
                cur_slot = slot_q.pop_front();
                i_s_axis_tdata <= {cur_slot.miso, cur_slot.wdata, cur_slot.addr};
                i_s_axis_tuser <= {cur_slot.op, cur_slot.first};
                i_s_axis_tlast <= cur_slot.last;
                i_s_axis_tvalid <= 1'b1;
                if (burst_left != 0) burst_left--;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 12);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
                end
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver: stall pattern picked anew from four at regular intervals; checks each pin state taken
    always @(posedge i_clk) begin
        t_pin want;
        cyc++;
        if (cyc % 128 == 0) stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0: i_m_axis_tready <= 1'b1;
            1: i_m_axis_tready <= $urandom_range(0, 1);
            2: i_m_axis_tready <= (cyc % 4 == 0);
            default: i_m_axis_tready <= (cyc % 32 >= 12);
        endcase
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            n_states++;
            if (pending_pins.size() == 0) begin
                report_mismatch("unexpected pin state, tdata", o_m_axis_tdata, 0);
            end else begin
                want = pending_pins.pop_front();
                if (o_m_axis_tdata[0] !== want.sck)
                    report_mismatch("sck", o_m_axis_tdata[0], want.sck);
                if (o_m_axis_tdata[1] !== want.mosi)
                    report_mismatch("mosi", o_m_axis_tdata[1], want.mosi);
                if (o_m_axis_tdata[2] !== want.cs_n)
                    report_mismatch("cs_n", o_m_axis_tdata[2], want.cs_n);
                if (o_m_axis_tdata[3] !== want.sample)
                    report_mismatch("sample", o_m_axis_tdata[3], want.sample);
                if (o_m_axis_tdata[11:4] !== want.rx_byte)
                    report_mismatch("rx_byte", o_m_axis_tdata[11:4], want.rx_byte);
                if (o_m_axis_tdata[15:12] !== 4'h0)
                    report_mismatch("tdata pad", o_m_axis_tdata[15:12], 0);
                if (o_m_axis_tuser[0] !== want.rx_valid)
                    report_mismatch("rx_valid", o_m_axis_tuser[0], want.rx_valid);
                if (o_m_axis_tlast !== want.end_of_run)
                    report_mismatch("end_of_run", o_m_axis_tlast, want.end_of_run);
            end
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready)
            || (o_m_axis_tvalid && i_m_axis_tready)) begin
            idle_cnt <= 0;
        end else if (idle_cnt >= IDLE_LIMIT) begin
            $display("watchdog expired at %0t", $time);
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cnt <= idle_cnt + 1;
        end
    end

    task automatic queue_slot(input logic first, input logic op, input logic [7:0] addr,
                              input logic [7:0] wdata, input logic last,
                              input logic [7:0] miso);
        t_spi_slot s;
        s.first = first;
        s.op = op;
        s.addr = addr;
        s.wdata = wdata;
        s.last = last;
        s.miso = miso;
        slot_q.push_back(s);
        n_pushed++;
    endtask

    task automatic queue_noise();
        queue_slot($urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 255),
                   $urandom_range(0, 255), $urandom_range(0, 1), $urandom_range(0, 255));
    endtask

    // one access; a long one may run into the payload limit unless tlast comes first
    task automatic queue_access(input bit force_long);
        int unsigned n;
        bit          long_run;
        bit          end_flag;
        long_run = force_long || ($urandom_range(0, 19) == 0);
        n = force_long ? 34 : (long_run ? $urandom_range(29, 34) : $urandom_range(0, 5));
        end_flag = force_long || !long_run || $urandom_range(0, 1);
        queue_slot(1'b1, $urandom_range(0, 1), $urandom_range(0, 255), $urandom_range(0, 255),
                   n == 0, $urandom_range(0, 255));
        for (int unsigned k = 1; k <= n; k++)
            queue_slot(1'b0, $urandom_range(0, 1), $urandom_range(0, 255),
                       $urandom_range(0, 255), end_flag && (k == n), $urandom_range(0, 255));
    endtask

    task automatic wait_idle();
        while (n_taken != n_pushed || pending_pins.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_SPI_MODE) mode_q = val;
        else if (idx == CFG_ENABLE) en_q = val[0];
    endtask

    task automatic queue_mode_phase(input bit first_phase);
        int unsigned start;
        start = n_pushed;
        if (first_phase) queue_access(1'b1);
        while (n_pushed - start < ITEMS_PER_MODE) begin
            if ($urandom_range(0, 9) == 0) queue_noise();
            else queue_access(1'b0);
        end
    endtask

    initial begin
        logic [1:0] modes[4];
        modes = '{2'd3, 2'd1, 2'd2, 2'd0};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // disabled after reset: nothing comes out
        queue_slot(1'b1, OP_WRITE, 8'h12, 8'h34, 1'b0, 8'hFF);
        queue_slot(1'b0, OP_READ, 8'h00, 8'hFF, 1'b1, 8'h00);
        queue_slot(1'b1, OP_READ, 8'hFF, 8'h00, 1'b1, 8'hA5);
        wait_idle();
        write_reg(CFG_ENABLE, 1);
        write_reg(CFG_SPI_MODE, 0);

        queue_slot(1'b0, OP_WRITE, 8'h55, 8'hAA, 1'b0, 8'h5A);  // payload outside access
        queue_slot(1'b1, OP_WRITE, 8'hFF, 8'h00, 1'b0, 8'hFF);
        queue_slot(1'b0, OP_READ, 8'h00, 8'h00, 1'b0, 8'h00);
        queue_slot(1'b0, OP_READ, 8'h00, 8'hFF, 1'b1, 8'hA5);
        queue_slot(1'b1, OP_READ, 8'h00, 8'h00, 1'b0, 8'h00);
        queue_slot(1'b0, OP_WRITE, 8'hFF, 8'hFF, 1'b1, 8'hFF);  // read sends zero
        queue_slot(1'b1, OP_READ, 8'h7F, 8'h00, 1'b1, 8'h3C);   // command only
        queue_slot(1'b1, OP_WRITE, 8'h80, 8'h00, 1'b0, 8'h01);
        queue_slot(1'b0, OP_READ, 8'h00, 8'h81, 1'b0, 8'h80);
        queue_slot(1'b1, OP_READ, 8'h34, 8'h00, 1'b0, 8'h7E);   // restart with cs low
        queue_slot(1'b0, OP_READ, 8'h00, 8'h00, 1'b1, 8'hC3);
        queue_slot(1'b0, OP_WRITE, 8'h00, 8'h00, 1'b1, 8'h00);  // outside access, tlast
        wait_idle();

        foreach (modes[m]) begin
            write_reg(CFG_SPI_MODE, modes[m]);
            queue_mode_phase(m == 0);
            wait_idle();
            if (m == 1) begin
                write_reg(CFG_ENABLE, 0);
                repeat (10) queue_noise();
                wait_idle();
                write_reg(CFG_ENABLE, 1);
            end
        end

        repeat (30) @(posedge i_clk);
        $display("sent %0d byte slots in all four spi modes, enable toggled off and on",
                 n_taken);
        $display("checked %0d pin states, %0d payload limit cut-offs", n_states, n_cutoffs);
        if (n_errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches", n_errors);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
